### rtl/core/index_chain_splitter_top_assert.svh
// Assertion macros shared by the index chain splitter checkers.
`ifndef INDEX_CHAIN_SPLITTER_TOP_ASSERT_SVH
`define INDEX_CHAIN_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define ICS_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("index chain splitter check failed");

// Next-cycle implication, sampled on clk and disabled while in reset.
`define ICS_ASSERT_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("index chain splitter check failed");

`endif

### rtl/core/ics_pkg.sv
// Shared constants, codes and types of the index chain splitter.
package ics_pkg;

  // Sizing of the chain window and of the stream fields.
  localparam int MAX_CHAIN_LIMIT = 64;
  localparam int INDEX_BITS      = 32;
  localparam int SYMBOL_BITS     = 16;
  localparam int OUT_IDX_BITS    = 32;
  localparam int MAXC_BITS       = 7;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 16;

  // Window slot index and per-chain visible count widths.
  localparam int SLOT_BITS = (MAX_CHAIN_LIMIT > 1) ? $clog2(MAX_CHAIN_LIMIT) : 1;
  localparam int SUM_BITS  = SLOT_BITS + 1;
  localparam int CNT_BITS  = $clog2(MAX_CHAIN_LIMIT + 1);
  localparam int WORD_BITS = CNT_BITS + INDEX_BITS;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CHAIN    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPACE_CODE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BREAK_CODE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_CODE     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_EPSILON_CODE = 3'd4;

  // Register reset values.
  localparam logic [MAXC_BITS-1:0]   RST_MAX_CHAIN    = 7'd8;
  localparam logic [SYMBOL_BITS-1:0] RST_SPACE_CODE   = SYMBOL_BITS'(32);
  localparam logic [SYMBOL_BITS-1:0] RST_BREAK_CODE   = SYMBOL_BITS'(1);
  localparam logic [SYMBOL_BITS-1:0] RST_END_CODE     = SYMBOL_BITS'(65535);
  localparam logic [SYMBOL_BITS-1:0] RST_EPSILON_CODE = SYMBOL_BITS'(0);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // One result beat.
  typedef struct packed {
    logic                    chain_valid;
    logic [OUT_IDX_BITS-1:0] chain_first;
    logic [OUT_IDX_BITS-1:0] chain_final;
    status_t                 status;
    logic                    run_last;
  } result_t;

endpackage

### rtl/core/index_chain_splitter_top.sv
// Index chain splitter: cuts a symbol stream into chain descriptors.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | in_sym, in_stream_last
//  out     | output    | out_valid / out_ready| chain_valid, chain_first, chain_final,
//          |           |                      | status, run_last
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// A boundary or error symbol passes through S_EVAL and S_END; a visible symbol also
// visits S_POPRD, then S_POPCHK for each chain it checks or reports. The stream's last
// beat, unless the stream is being dropped, visits S_FLRD and S_FLOUT per chain flushed.
// Each chain is read through the single registered read port of the chain window memory.
// Reset is synchronous and active low; the window needs no clearing pass.
// A stalled output holds the sequencer once one result is already waiting.
module index_chain_splitter_top import ics_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SYMBOL_BITS-1:0]   in_sym,
  input  logic                     in_stream_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_chain_valid,
  output logic [OUT_IDX_BITS-1:0]  out_chain_first,
  output logic [OUT_IDX_BITS-1:0]  out_chain_final,
  output logic [1:0]               out_status,
  output logic                     out_run_last
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EVAL   = 7'b0000010,
    S_POPRD  = 7'b0000100,
    S_POPCHK = 7'b0001000,
    S_FLRD   = 7'b0010000,
    S_FLOUT  = 7'b0100000,
    S_END    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [MAXC_BITS-1:0]   max_chain_r;
  logic [SYMBOL_BITS-1:0] space_code_r, break_code_r, end_code_r, epsilon_code_r;

  // Captured input beat.
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic                   last_r, last_nxt;

  // Stream state.
  logic [INDEX_BITS:0]    position_r, position_nxt;
  logic                   after_boundary_r, after_boundary_nxt;
  logic [CNT_BITS-1:0]    run_phase_r, run_phase_nxt;
  logic [CNT_BITS-1:0]    vis_cnt_r, vis_cnt_nxt;
  logic [SLOT_BITS-1:0]   head_r, head_nxt;
  logic [CNT_BITS-1:0]    len_r, len_nxt;
  logic [INDEX_BITS-1:0]  last_visible_r, last_visible_nxt;
  logic                   dropping_r, dropping_nxt;

  // Held result (kept back until its run_last flag is known) and output register.
  result_t held_r, held_nxt;
  logic    held_v_r, held_v_nxt;
  result_t out_r, out_nxt;
  logic    out_valid_r, out_valid_nxt;

  // Chain window memory: start tag (visible count) and start index per entry.
  logic [WORD_BITS-1:0] win_mem [0:MAX_CHAIN_LIMIT-1];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 mem_we, mem_re;
  logic [SLOT_BITS-1:0] mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // Combinational helpers.
  logic [CNT_BITS-1:0]   m_eff;
  logic                  out_free, can_emit;
  logic                  is_bnd, is_bad, opens;
  logic [INDEX_BITS-1:0] cur_idx;
  logic [SUM_BITS-1:0]   tail_sum;
  logic [SLOT_BITS-1:0]  tail, head_inc;
  logic [CNT_BITS-1:0]   phase_inc, head_count;
  logic [INDEX_BITS-1:0] rd_start;
  logic [CNT_BITS-1:0]   rd_tag;
  result_t               chain_res;

  // Effective chain length: zero acts as one, large values clamp to the limit.
  always_comb begin
    if (max_chain_r == '0) begin
      m_eff = CNT_BITS'(1);
    end else if (max_chain_r > MAXC_BITS'(MAX_CHAIN_LIMIT)) begin
      m_eff = CNT_BITS'(MAX_CHAIN_LIMIT);
    end else begin
      m_eff = CNT_BITS'(max_chain_r);
    end
  end

  // Symbol classification; a boundary code wins over the invalid codes.
  assign is_bnd  = (sym_r == space_code_r) || (sym_r == break_code_r);
  assign is_bad  = (sym_r >= end_code_r) || (sym_r == epsilon_code_r);
  assign opens   = after_boundary_r || (run_phase_r == '0);
  assign cur_idx = position_r[INDEX_BITS-1:0];

  // Ring pointer arithmetic for the window.
  assign tail_sum = SUM_BITS'(head_r) + SUM_BITS'(len_r);
  assign tail     = (tail_sum >= SUM_BITS'(MAX_CHAIN_LIMIT)) ?
                    SLOT_BITS'(tail_sum - SUM_BITS'(MAX_CHAIN_LIMIT)) :
                    SLOT_BITS'(tail_sum);
  assign head_inc = (head_r == SLOT_BITS'(MAX_CHAIN_LIMIT - 1)) ?
                    '0 : head_r + SLOT_BITS'(1);
  assign phase_inc = run_phase_r + CNT_BITS'(1);

  // Head entry as read from the window, and its visible count.
  assign rd_start   = rd_data_r[INDEX_BITS-1:0];
  assign rd_tag     = rd_data_r[WORD_BITS-1:INDEX_BITS];
  assign head_count = vis_cnt_r - rd_tag;

  // Chain descriptor from the head entry, ending at the last visible symbol.
  always_comb begin
    chain_res             = '0;
    chain_res.chain_valid = 1'b1;
    chain_res.chain_first = OUT_IDX_BITS'(rd_start);
    chain_res.chain_final = OUT_IDX_BITS'(last_visible_r);
    chain_res.status      = ST_OK;
    chain_res.run_last    = 1'b0;
  end

  assign out_free = !out_valid_r || out_ready;
  assign can_emit = !held_v_r || out_free;

  // Sequencer.
  always_comb begin
    state_nxt          = state_r;
    sym_nxt            = sym_r;
    last_nxt           = last_r;
    position_nxt       = position_r;
    after_boundary_nxt = after_boundary_r;
    run_phase_nxt      = run_phase_r;
    vis_cnt_nxt        = vis_cnt_r;
    head_nxt           = head_r;
    len_nxt            = len_r;
    last_visible_nxt   = last_visible_r;
    dropping_nxt       = dropping_r;
    held_nxt           = held_r;
    held_v_nxt         = held_v_r;
    out_nxt            = out_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    mem_we             = 1'b0;
    mem_waddr          = tail;
    mem_wdata          = {vis_cnt_r, cur_idx};
    mem_re             = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt   = in_sym;
          last_nxt  = in_stream_last;
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (dropping_r) begin
          state_nxt = S_END;
        end else if (position_r[INDEX_BITS]) begin
          // Index overflow: one error result, then drop the stream.
          held_nxt        = '0;
          held_nxt.status = ST_OVERFLOW;
          held_v_nxt      = 1'b1;
          dropping_nxt    = 1'b1;
          len_nxt         = '0;
          state_nxt       = S_END;
        end else begin
          position_nxt = position_r + (INDEX_BITS + 1)'(1);
          if (is_bnd) begin
            after_boundary_nxt = 1'b1;
            run_phase_nxt      = '0;
            state_nxt          = last_r ? S_FLRD : S_END;
          end else if (is_bad) begin
            held_nxt             = '0;
            held_nxt.chain_first = OUT_IDX_BITS'(cur_idx);
            held_nxt.status      = ST_INVALID;
            held_v_nxt           = 1'b1;
            dropping_nxt         = 1'b1;
            len_nxt              = '0;
            state_nxt            = S_END;
          end else begin
            // Visible symbol: maybe open a chain, then count it for all chains.
            after_boundary_nxt = 1'b0;
            run_phase_nxt      = (phase_inc >= m_eff) ? '0 : phase_inc;
            if (opens && (len_r < CNT_BITS'(MAX_CHAIN_LIMIT))) begin
              mem_we  = 1'b1;
              len_nxt = len_r + CNT_BITS'(1);
            end
            vis_cnt_nxt      = vis_cnt_r + CNT_BITS'(1);
            last_visible_nxt = cur_idx;
            state_nxt        = S_POPRD;
          end
        end
      end

      S_POPRD: begin
        if (len_r == '0) begin
          state_nxt = last_r ? S_FLRD : S_END;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_POPCHK;
        end
      end

      S_POPCHK: begin
        if (head_count >= m_eff) begin
          if (can_emit) begin
            if (held_v_r) begin
              out_nxt       = held_r;
              out_valid_nxt = 1'b1;
            end
            held_nxt   = chain_res;
            held_v_nxt = 1'b1;
            head_nxt   = head_inc;
            len_nxt    = len_r - CNT_BITS'(1);
            state_nxt  = S_POPRD;
          end
        end else begin
          state_nxt = last_r ? S_FLRD : S_END;
        end
      end

      S_FLRD: begin
        if (len_r == '0) begin
          state_nxt = S_END;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_FLOUT;
        end
      end

      S_FLOUT: begin
        if (can_emit) begin
          if (held_v_r) begin
            out_nxt       = held_r;
            out_valid_nxt = 1'b1;
          end
          held_nxt   = chain_res;
          held_v_nxt = 1'b1;
          head_nxt   = head_inc;
          len_nxt    = len_r - CNT_BITS'(1);
          state_nxt  = S_FLRD;
        end
      end

      S_END: begin
        if (!held_v_r || out_free) begin
          // The held result is the last one of this step.
          if (held_v_r) begin
            out_nxt          = held_r;
            out_nxt.run_last = 1'b1;
            out_valid_nxt    = 1'b1;
            held_v_nxt       = 1'b0;
          end
          if (last_r) begin
            position_nxt       = '0;
            after_boundary_nxt = 1'b1;
            run_phase_nxt      = '0;
            vis_cnt_nxt        = '0;
            head_nxt           = '0;
            len_nxt            = '0;
            last_visible_nxt   = '0;
            dropping_nxt       = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and stream state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      position_r       <= '0;
      after_boundary_r <= 1'b1;
      run_phase_r      <= '0;
      vis_cnt_r        <= '0;
      head_r           <= '0;
      len_r            <= '0;
      last_visible_r   <= '0;
      dropping_r       <= 1'b0;
      held_v_r         <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      position_r       <= position_nxt;
      after_boundary_r <= after_boundary_nxt;
      run_phase_r      <= run_phase_nxt;
      vis_cnt_r        <= vis_cnt_nxt;
      head_r           <= head_nxt;
      len_r            <= len_nxt;
      last_visible_r   <= last_visible_nxt;
      dropping_r       <= dropping_nxt;
      held_v_r         <= held_v_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chain_r    <= RST_MAX_CHAIN;
      space_code_r   <= RST_SPACE_CODE;
      break_code_r   <= RST_BREAK_CODE;
      end_code_r     <= RST_END_CODE;
      epsilon_code_r <= RST_EPSILON_CODE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_CHAIN:    max_chain_r    <= cfg_data[MAXC_BITS-1:0];
        REG_SPACE_CODE:   space_code_r   <= SYMBOL_BITS'(cfg_data);
        REG_BREAK_CODE:   break_code_r   <= SYMBOL_BITS'(cfg_data);
        REG_END_CODE:     end_code_r     <= SYMBOL_BITS'(cfg_data);
        REG_EPSILON_CODE: epsilon_code_r <= SYMBOL_BITS'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Window memory: one write port, one registered read port at the head.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= win_mem[head_r];
    end
  end

  // Ports.
  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_chain_valid = out_r.chain_valid;
  assign out_chain_first = out_r.chain_first;
  assign out_chain_final = out_r.chain_final;
  assign out_status      = out_r.status;
  assign out_run_last    = out_r.run_last;

endmodule

### rtl/core/ics_checker.sv
// Port-level checker of the index chain splitter and its bind.
`include "index_chain_splitter_top_assert.svh"

module ics_checker import ics_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_chain_valid,
  input logic [OUT_IDX_BITS-1:0] out_chain_first,
  input logic [OUT_IDX_BITS-1:0] out_chain_final,
  input logic [1:0]              out_status,
  input logic                    out_run_last
);

  logic [2*OUT_IDX_BITS+3:0] out_payload;
  logic                      chain_ok;
  logic                      error_ok;

  // Whole result beat, and the shapes a chain or an error result must have.
  assign out_payload = {out_chain_valid, out_chain_first, out_chain_final,
                        out_status, out_run_last};
  assign chain_ok    = (out_status == ST_OK) && (out_chain_first <= out_chain_final);
  assign error_ok    = out_run_last && (out_chain_final == '0) &&
                       ((out_status == ST_INVALID) || (out_status == ST_OVERFLOW));

  // A stalled result beat stays put.
  `ICS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // The block works on one symbol at a time.
  `ICS_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // A chain descriptor is ok and never ends before it starts.
  `ICS_ASSERT_IMP(a_chain_order, out_valid && out_chain_valid, chain_ok)

  // An error result is the only and last result of its symbol.
  `ICS_ASSERT_IMP(a_error_form, out_valid && !out_chain_valid, error_ok)

endmodule

bind index_chain_splitter_top ics_checker u_ics_checker (.*);

### bench/tb_index_chain_splitter_top.sv
// Self-checking testbench for the index chain splitter top level.
`timescale 1ns / 1ps

module tb_index_chain_splitter_top;
  import ics_pkg::*;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int QUIET_LIMIT = 3000;
  // Cycles to let the block settle when no further result is expected.
  localparam int SETTLE_CYCLES = 16;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES = 400;
  localparam logic [INDEX_BITS:0] IDX_TOP = {1'b0, {INDEX_BITS{1'b1}}};

  // One open chain: its start index and the visible symbols it has seen.
  typedef struct {
    logic [INDEX_BITS-1:0] start_idx;
    int unsigned           seen;
  } open_chain_t;

  // Predicts chain descriptors from accepted symbols and checks result beats.
  class chain_scoreboard;
    logic [MAXC_BITS-1:0]   max_chain;
    logic [SYMBOL_BITS-1:0] space_code;
    logic [SYMBOL_BITS-1:0] break_code;
    logic [SYMBOL_BITS-1:0] end_code;
    logic [SYMBOL_BITS-1:0] epsilon_code;

    logic [INDEX_BITS:0]   position;
    bit                    after_boundary;
    int unsigned           run_phase;
    open_chain_t           chains[$];
    logic [INDEX_BITS-1:0] last_visible;
    bit                    dropping;

    result_t expected_q[$];
    int      errors;

    function new();
      max_chain    = RST_MAX_CHAIN;
      space_code   = RST_SPACE_CODE;
      break_code   = RST_BREAK_CODE;
      end_code     = RST_END_CODE;
      epsilon_code = RST_EPSILON_CODE;
      errors       = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      position       = '0;
      after_boundary = 1'b1;
      run_phase      = 0;
      chains.delete();
      last_visible   = '0;
      dropping       = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_MAX_CHAIN:    max_chain    = data[MAXC_BITS-1:0];
        REG_SPACE_CODE:   space_code   = data;
        REG_BREAK_CODE:   break_code   = data;
        REG_END_CODE:     end_code     = data;
        REG_EPSILON_CODE: epsilon_code = data;
        default: ;
      endcase
    endfunction

    function result_t make_result(logic valid, logic [INDEX_BITS-1:0] first_idx,
                                  logic [INDEX_BITS-1:0] last_idx, status_t st);
      result_t r;
      r.chain_valid = valid;
      r.chain_first = first_idx;
      r.chain_final = last_idx;
      r.status      = st;
      r.run_last    = 1'b0;
      return r;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Works out every result caused by one accepted input beat.
    function void note_symbol(logic [SYMBOL_BITS-1:0] sym, logic last);
      result_t               step_q[$];
      int unsigned           m;
      logic [INDEX_BITS-1:0] idx;
      bit                    opens;
      open_chain_t           oc;
      m = (max_chain == 0) ? 1 : (max_chain > MAX_CHAIN_LIMIT) ? MAX_CHAIN_LIMIT : max_chain;
      if (!dropping) begin
        if (position > IDX_TOP) begin
          step_q.insert(step_q.size(), make_result(1'b0, '0, '0, ST_OVERFLOW));
          dropping = 1'b1;
          chains.delete();
        end else begin
          idx = position[INDEX_BITS-1:0];
          position++;
          if (sym == space_code || sym == break_code) begin
            // Boundary codes win over every other code.
            after_boundary = 1'b1;
            run_phase      = 0;
          end else if (sym >= end_code || sym == epsilon_code) begin
            step_q.insert(step_q.size(), make_result(1'b0, idx, '0, ST_INVALID));
            dropping = 1'b1;
            chains.delete();
          end else begin
            opens          = after_boundary || run_phase == 0;
            after_boundary = 1'b0;
            run_phase      = (run_phase + 1 >= m) ? 0 : run_phase + 1;
            if (opens && chains.size() < MAX_CHAIN_LIMIT) begin
              oc.start_idx = idx;
              oc.seen      = 0;
              chains.insert(chains.size(), oc);
            end
            foreach (chains[i]) chains[i].seen++;
            last_visible = idx;
            while (chains.size() > 0 && chains[0].seen >= m) begin
              step_q.insert(step_q.size(),
                            make_result(1'b1, chains[0].start_idx, idx, ST_OK));
              void'(chains.pop_front());
            end
          end
        end
      end
      // The stream's last beat flushes whatever is still open.
      if (last) begin
        if (!dropping) begin
          while (chains.size() > 0) begin
            step_q.insert(step_q.size(),
                          make_result(1'b1, chains[0].start_idx, last_visible, ST_OK));
            void'(chains.pop_front());
          end
        end
        clear_stream();
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
      foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compares one result beat with the oldest expected one.
    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result v=%0b first=%0d last=%0d st=%0d rl=%0b",
                         got.chain_valid, got.chain_first, got.chain_final,
                         got.status, got.run_last));
        return;
      end
      want = expected_q.pop_front();
      if (got.chain_valid !== want.chain_valid || got.chain_first !== want.chain_first ||
          got.chain_final !== want.chain_final || got.status !== want.status ||
          got.run_last !== want.run_last) begin
        report($sformatf("got v=%0b f=%0d l=%0d st=%0d rl=%0b want v=%0b f=%0d l=%0d st=%0d rl=%0b",
                         got.chain_valid, got.chain_first, got.chain_final, got.status,
                         got.run_last, want.chain_valid, want.chain_first,
                         want.chain_final, want.status, want.run_last));
      end
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [SYMBOL_BITS-1:0]   in_sym = '0;
  logic                     in_stream_last = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_chain_valid;
  logic [OUT_IDX_BITS-1:0]  out_chain_first;
  logic [OUT_IDX_BITS-1:0]  out_chain_final;
  logic [1:0]               out_status;
  logic                     out_run_last;

  chain_scoreboard sb = new();

  bit hold_start = 1'b0;
  bit calm = 1'b0;
  int sent_count = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  index_chain_splitter_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sym          (in_sym),
    .in_stream_last  (in_stream_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_chain_valid (out_chain_valid),
    .out_chain_first (out_chain_first),
    .out_chain_final (out_chain_final),
    .out_status      (out_status),
    .out_run_last    (out_run_last)
  );

  // Receiver: checks each accepted result beat and paces out_ready.
  always @(posedge clk) begin : rx_side
    result_t got;
    static int stall_left = 0;
    static int hold_left = 0;
    static int stall_pct = 30;
    static int mode_cycles = 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.chain_valid = out_chain_valid;
        got.chain_first = out_chain_first;
        got.chain_final = out_chain_final;
        got.status      = status_t'(out_status);
        got.run_last    = out_run_last;
        sb.check_result(got);
      end
      // Switch between stall-heavy and stall-free stretches now and then.
      mode_cycles++;
      if (mode_cycles >= 64) begin
        mode_cycles = 0;
        stall_pct   = ($urandom_range(2, 0) == 0) ? 0 : ($urandom_range(1, 0) ? 25 : 60);
      end
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99, 0) < stall_pct) begin
        stall_left = $urandom_range(6, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Writes all five registers in turn; valid stays high between beats.
  task automatic program_regs(logic [15:0] mc, logic [15:0] sp, logic [15:0] br,
                              logic [15:0] en, logic [15:0] ep);
    logic [CFG_DATA_BITS-1:0] vals [5];
    logic [CFG_IDX_BITS-1:0]  regs [5];
    int i;
    vals = '{mc, sp, br, en, ep};
    regs = '{REG_MAX_CHAIN, REG_SPACE_CODE, REG_BREAK_CODE, REG_END_CODE, REG_EPSILON_CODE};
    for (i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random codes for a phase; max_chain is given by the caller.
  task automatic random_regs(logic [15:0] mc);
    program_regs(mc, 16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(16'hFFFF, 0)),
                 16'($urandom_range(16'hFFFF, 16'h0100)), 16'($urandom_range(16'hFFFF, 0)));
  endtask

  // Offers one symbol beat, after an optional random gap, and waits for it.
  task automatic send(logic [SYMBOL_BITS-1:0] sym, logic last, int gap_pct = 30);
    int gap;
    gap = (calm || $urandom_range(99, 0) >= gap_pct) ? 0 : $urandom_range(7, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sym         <= sym;
    in_stream_last <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_symbol(sym, last);
    sent_count++;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [SYMBOL_BITS-1:0] pick_visible();
    logic [SYMBOL_BITS-1:0] v;
    do begin
      v = 16'($urandom_range(sb.end_code - 1, 0));
    end while (v == sb.space_code || v == sb.break_code || v == sb.epsilon_code);
    return v;
  endfunction

  function automatic logic [SYMBOL_BITS-1:0] pick_symbol();
    int r;
    r = $urandom_range(99, 0);
    if (r < 15) return sb.space_code;
    if (r < 22) return sb.break_code;
    if (r < 26) return 16'($urandom_range(16'hFFFF, 0));
    return pick_visible();
  endfunction

  function automatic logic [SYMBOL_BITS-1:0] pick_invalid();
    if ($urandom_range(1, 0)) return sb.epsilon_code;
    return 16'($urandom_range(16'hFFFF, sb.end_code));
  endfunction

  // Mostly well-formed streams of random content, some broken by a bad symbol.
  task automatic random_phase(int n_items, bit dense, bit mid_pause);
    int first_count, len, k, bad_at, gap_pct;
    bit paused;
    first_count = sent_count;
    paused      = 1'b0;
    if (dense) begin
      // Many chains open at once, the oldest reaching the full chain length.
      for (k = 0; k < 32; k++) begin
        send(pick_visible(), 1'b0, 0);
        send(sb.space_code, 1'b0, 0);
      end
      for (k = 0; k < 32; k++) send(pick_visible(), k == 31, 0);
    end
    while (sent_count - first_count < n_items) begin
      len     = $urandom_range(20, 1);
      bad_at  = ($urandom_range(99, 0) < 15) ? $urandom_range(len - 1, 0) : -1;
      gap_pct = $urandom_range(1, 0) ? 35 : 0;
      for (k = 0; k < len; k++) begin
        send((k == bad_at) ? pick_invalid() : pick_symbol(), k == len - 1, gap_pct);
      end
      if (mid_pause && !paused && sent_count - first_count >= n_items / 2) begin
        paused = 1'b1;
        drain(0);
      end
    end
    drain(SETTLE_CYCLES);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Separated chains under reset codes, flushed by the stream end.
    send(16'h0041, 1'b0);
    send(RST_SPACE_CODE, 1'b0);
    send(16'h0042, 1'b0);
    send(RST_BREAK_CODE, 1'b0);
    send(16'h0043, 1'b1);
    // Code at the end marker is invalid; the rest of the stream is dropped.
    send(16'hFFFE, 1'b0);
    send(16'h8001, 1'b0);
    send(16'hFFFF, 1'b0);
    send(16'h1234, 1'b0);
    send(16'h0041, 1'b1);
    // Epsilon on the last beat of a stream.
    send(RST_EPSILON_CODE, 1'b1);
    drain(SETTLE_CYCLES);

    // Boundary codes that collide with epsilon and with the invalid range.
    program_regs(16'd8, 16'h0000, 16'hFFFF, 16'h8000, 16'h0000);
    send(16'h0000, 1'b0);
    send(16'h7FFF, 1'b0);
    send(16'hFFFF, 1'b0);
    send(16'h0002, 1'b1);
    drain(SETTLE_CYCLES);

    // A chain length of zero behaves as one.
    program_regs(16'd0, RST_SPACE_CODE, RST_BREAK_CODE, RST_END_CODE, RST_EPSILON_CODE);
    send(16'h0005, 1'b0);
    send(16'h0006, 1'b1);
    drain(SETTLE_CYCLES);

    // Chain length lowered while a chain is open.
    program_regs(16'd4, RST_SPACE_CODE, RST_BREAK_CODE, RST_END_CODE, RST_EPSILON_CODE);
    send(16'h0061, 1'b0);
    send(16'h0062, 1'b0);
    send(16'h0063, 1'b0);
    drain(SETTLE_CYCLES);
    program_regs(16'd2, RST_SPACE_CODE, RST_BREAK_CODE, RST_END_CODE, RST_EPSILON_CODE);
    send(16'h0064, 1'b0);
    send(16'h0065, 1'b1);
    drain(SETTLE_CYCLES);

    // A chain length above the limit is clamped.
    program_regs(16'd100, RST_SPACE_CODE, RST_BREAK_CODE, RST_END_CODE, RST_EPSILON_CODE);
    send(16'h0070, 1'b0);
    send(16'h0071, 1'b0);
    send(16'h0072, 1'b1);
    drain(SETTLE_CYCLES);

    // Random phases; the first one starts under a long receiver hold-off.
    random_regs(16'd1);
    hold_start = 1'b1;
    random_phase(12, 1'b0, 1'b0);
    random_regs(16'd64);
    random_phase(24, 1'b1, 1'b0);
    random_regs(16'($urandom_range(9, 2)));
    random_phase(12, 1'b0, 1'b1);
    random_regs(16'd0);
    random_phase(12, 1'b0, 1'b0);
    random_regs({9'($urandom_range(511, 0)), 7'd127});
    random_phase(12, 1'b0, 1'b0);
    calm = 1'b1;
    program_regs(16'($urandom_range(9, 2)), 16'($urandom_range(16'hFFFF, 0)),
                 16'($urandom_range(16'hFFFF, 0)), 16'hFFFF, 16'($urandom_range(16'hFFFF, 0)));
    random_phase(12, 1'b0, 1'b0);

    drain(40);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
